FILE: design/ugbt_pkg.sv
// shared types, codes and defaults of the uniform grid bucket table
package ugbt_pkg;

    localparam int MAX_DEPTH_DEF = 4;
    localparam int CAPACITY_DEF  = 16;
    localparam int COORD_W       = 32;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_OOB       = 2'd3;

    // actions
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;
    localparam logic [2:0] REG_DEPTH = 3'd6;

    typedef struct packed {
        logic               action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [63:0]        instance_id;
        logic [63:0]        program_id;
        logic [31:0]        instance_slot;
        logic [31:0]        index_start;
        logic [31:0]        index_count;
        logic [31:0]        vertex_start;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] cell_index;
        logic [3:0]  entry_slot;
    } rsp_t;

endpackage

FILE: design/uniform_grid_bucket_table.sv
// top level of the uniform grid bucket table: sequencer, bucket counts and entry store
// an add works out the cell on the three axes, then reads its count; a remove also scans
//   the slots of the home cell, then of its neighbours (27 places), and moves each later entry up
// one transaction at a time, busy is high from accept until the result strobe
// the single divider serves the three axes in turn; one port serves entry reads and writes
// after reset a clearing pass zeroes every bucket count, 2^(3*MAX_DEPTH) of them (4096 here)
// results are shown for one cycle on done; the receiver cannot stall
module uniform_grid_bucket_table #(
    parameter int MAX_DEPTH = ugbt_pkg::MAX_DEPTH_DEF,
    parameter int CAPACITY  = ugbt_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ugbt_pkg::req_t   req,
    output logic             done,
    output ugbt_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam int AW      = MAX_DEPTH;
    localparam int DW      = $clog2(MAX_DEPTH + 1);
    localparam int CW      = 3 * MAX_DEPTH;
    localparam int CELLS   = 1 << CW;
    localparam int SW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW    = $clog2(CAPACITY + 1);
    localparam int EAW     = CW + $clog2(CAPACITY);
    localparam int ENTRIES = CELLS * CAPACITY;
    localparam int EW      = 256;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_AXIS  = 4'd2;
    localparam logic [3:0] S_DIVW  = 4'd3;
    localparam logic [3:0] S_HOME  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CNT   = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SCMP  = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_NCHK  = 4'd10;
    localparam logic [3:0] S_MRD   = 4'd11;
    localparam logic [3:0] S_MWR   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    // configuration
    logic signed [31:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [31:0] max_x_reg, max_y_reg, max_z_reg;
    logic [2:0]         depth_reg;

    // sequencer
    logic [3:0]      state_reg;
    logic [1:0]      axis_reg;
    logic [AW-1:0]   cx_reg, cy_reg, cz_reg;
    logic [CW-1:0]   home_reg;
    logic [CW-1:0]   cell_reg;
    logic [CW-1:0]   clr_reg;
    logic [CNTW-1:0] i_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [SW-1:0]   slot_reg;
    logic            nb_reg;
    logic [1:0]      dx_reg, dy_reg, dz_reg;
    ugbt_pkg::req_t  req_reg;
    ugbt_pkg::rsp_t  rsp_reg;
    logic            done_reg;

    // memories
    logic [CNTW-1:0] cnt_mem [CELLS];
    logic [CNTW-1:0] cnt_rd_reg;
    logic [EW-1:0]   ent_mem [ENTRIES];
    logic [EW-1:0]   ent_rd_reg;

    logic [DW-1:0]      deff;
    logic [AW-1:0]      last_cell;
    logic signed [31:0] ax_p, ax_lo, ax_hi;
    logic               ax_oob;
    logic               div_go, div_done;
    logic [AW-1:0]      div_coord;
    logic [AW-1:0]      nx, ny, nz;
    logic               nb_ok;
    logic [CW-1:0]      home_lin, nb_lin;
    logic [CW-1:0]      cnt_addr;
    logic               cnt_we;
    logic [CNTW-1:0]    cnt_wdata;
    logic               cnt_re;
    logic [CNTW-1:0]    ent_sel;
    logic [EAW-1:0]     ent_addr;
    logic               ent_we, ent_re;
    logic [EW-1:0]      ent_wdata;
    logic [CNTW-1:0]    i_inc;

    // depth above the build limit behaves as the limit
    always_comb
    begin
        if (32'(depth_reg) > MAX_DEPTH)
            deff = DW'(MAX_DEPTH);
        else
            deff = DW'(depth_reg);
    end

    assign last_cell = AW'((32'd1 << deff) - 32'd1);
    assign i_inc     = i_reg + CNTW'(1);

    // axis operands for the shared divider
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                ax_p = req_reg.pos_x; ax_lo = min_x_reg; ax_hi = max_x_reg;
            end
            2'd1:
            begin
                ax_p = req_reg.pos_y; ax_lo = min_y_reg; ax_hi = max_y_reg;
            end
            default:
            begin
                ax_p = req_reg.pos_z; ax_lo = min_z_reg; ax_hi = max_z_reg;
            end
        endcase
    end

    // empty volume, or below / above the bounds
    assign ax_oob = (ax_hi <= ax_lo) || (ax_p < ax_lo) || (ax_p > ax_hi);
    assign div_go = (state_reg == S_AXIS) && !ax_oob;

    ugbt_div #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (32'(ax_p - ax_lo)),
        .den   (32'(ax_hi - ax_lo)),
        .depth (deff),
        .done  (div_done),
        .coord (div_coord)
    );

    // neighbour coordinates, offsets coded 0/1/2 for -1/0/+1
    assign nx = cx_reg + AW'(dx_reg) - AW'(1);
    assign ny = cy_reg + AW'(dy_reg) - AW'(1);
    assign nz = cz_reg + AW'(dz_reg) - AW'(1);

    assign nb_ok = !((cx_reg == '0) && (dx_reg == 2'd0)) &&
                   !((cx_reg == last_cell) && (dx_reg == 2'd2)) &&
                   !((cy_reg == '0) && (dy_reg == 2'd0)) &&
                   !((cy_reg == last_cell) && (dy_reg == 2'd2)) &&
                   !((cz_reg == '0) && (dz_reg == 2'd0)) &&
                   !((cz_reg == last_cell) && (dz_reg == 2'd2)) &&
                   !((dx_reg == 2'd1) && (dy_reg == 2'd1) && (dz_reg == 2'd1));

    assign home_lin = (CW'(cx_reg) << {deff, 1'b0}) | (CW'(cy_reg) << deff) | CW'(cz_reg);
    assign nb_lin   = (CW'(nx) << {deff, 1'b0}) | (CW'(ny) << deff) | CW'(nz);

    // bucket count port
    assign cnt_addr = (state_reg == S_CLEAR) ? clr_reg : cell_reg;
    assign cnt_re   = (state_reg == S_CRD);
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
            end
            S_CNT:
            begin
                if ((req_reg.action == ugbt_pkg::ACT_ADD) &&
                    (cnt_rd_reg < CNTW'(CAPACITY)))
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd_reg + CNTW'(1);
                end
            end
            S_FIN:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_reg - CNTW'(1);
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_addr] <= cnt_wdata;
        if (cnt_re)
            cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    // entry store port: one address shared by reads and writes
    always_comb
    begin
        case (state_reg)
            S_CNT:   ent_sel = cnt_rd_reg;
            S_MRD:   ent_sel = i_inc;
            default: ent_sel = i_reg;
        endcase
    end

    assign ent_addr = EAW'(cell_reg) * EAW'(CAPACITY) + EAW'(ent_sel);
    assign ent_re   = (state_reg == S_SRD) || (state_reg == S_MRD);
    assign ent_we   = ((state_reg == S_CNT) && (req_reg.action == ugbt_pkg::ACT_ADD) &&
                       (cnt_rd_reg < CNTW'(CAPACITY))) || (state_reg == S_MWR);
    assign ent_wdata = (state_reg == S_MWR) ? ent_rd_reg :
                       {req_reg.instance_id, req_reg.program_id, req_reg.instance_slot,
                        req_reg.index_start, req_reg.index_count, req_reg.vertex_start};

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_addr] <= ent_wdata;
        if (ent_re)
            ent_rd_reg <= ent_mem[ent_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= 32'sd0;
            min_y_reg <= 32'sd0;
            min_z_reg <= 32'sd0;
            max_x_reg <= 32'sd1048576;
            max_y_reg <= 32'sd1048576;
            max_z_reg <= 32'sd1048576;
            depth_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ugbt_pkg::REG_MIN_X: min_x_reg <= cfg_data;
                ugbt_pkg::REG_MIN_Y: min_y_reg <= cfg_data;
                ugbt_pkg::REG_MIN_Z: min_z_reg <= cfg_data;
                ugbt_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                ugbt_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                ugbt_pkg::REG_MAX_Z: max_z_reg <= cfg_data;
                ugbt_pkg::REG_DEPTH: depth_reg <= cfg_data[2:0];
                default:             depth_reg <= depth_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    // walk every bucket count once
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS:
                begin
                    if (ax_oob)
                    begin
                        rsp_reg   <= '{status: ugbt_pkg::ST_OOB, cell_index: '0,
                                       entry_slot: '0};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        case (axis_reg)
                            2'd0:    cx_reg <= div_coord;
                            2'd1:    cy_reg <= div_coord;
                            default: cz_reg <= div_coord;
                        endcase
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= S_HOME;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_AXIS;
                        end
                    end
                end
                S_HOME:
                begin
                    home_reg  <= home_lin;
                    cell_reg  <= home_lin;
                    nb_reg    <= 1'b0;
                    state_reg <= S_CRD;
                end
                S_CRD:
                begin
                    state_reg <= S_CNT;
                end
                S_CNT:
                begin
                    cnt_reg <= cnt_rd_reg;
                    i_reg   <= '0;
                    if (req_reg.action == ugbt_pkg::ACT_ADD)
                    begin
                        if (cnt_rd_reg >= CNTW'(CAPACITY))
                            rsp_reg <= '{status: ugbt_pkg::ST_FULL,
                                         cell_index: 12'(home_reg), entry_slot: '0};
                        else
                            rsp_reg <= '{status: ugbt_pkg::ST_OK,
                                         cell_index: 12'(home_reg),
                                         entry_slot: 4'(cnt_rd_reg)};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:
                begin
                    if (i_reg >= cnt_reg)
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    if (ent_rd_reg[EW-1 -: 64] == req_reg.instance_id)
                    begin
                        slot_reg  <= i_reg[SW-1:0];
                        state_reg <= S_MRD;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_SRD;
                    end
                end
                S_NEXT:
                begin
                    // home first, then the neighbours with z innermost
                    if (!nb_reg)
                    begin
                        nb_reg    <= 1'b1;
                        dx_reg    <= 2'd0;
                        dy_reg    <= 2'd0;
                        dz_reg    <= 2'd0;
                        state_reg <= S_NCHK;
                    end
                    else if ((dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2))
                    begin
                        rsp_reg   <= '{status: ugbt_pkg::ST_NOT_FOUND,
                                       cell_index: 12'(home_reg), entry_slot: '0};
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (dz_reg != 2'd2)
                        begin
                            dz_reg <= dz_reg + 2'd1;
                        end
                        else
                        begin
                            dz_reg <= 2'd0;
                            if (dy_reg != 2'd2)
                            begin
                                dy_reg <= dy_reg + 2'd1;
                            end
                            else
                            begin
                                dy_reg <= 2'd0;
                                dx_reg <= dx_reg + 2'd1;
                            end
                        end
                        state_reg <= S_NCHK;
                    end
                end
                S_NCHK:
                begin
                    if (nb_ok)
                    begin
                        cell_reg  <= nb_lin;
                        state_reg <= S_CRD;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_MRD:
                begin
                    // close the gap: move each later entry up one slot
                    if (i_inc >= cnt_reg)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_MWR;
                end
                S_MWR:
                begin
                    i_reg     <= i_inc;
                    state_reg <= S_MRD;
                end
                S_FIN:
                begin
                    rsp_reg   <= '{status: ugbt_pkg::ST_OK, cell_index: 12'(cell_reg),
                                   entry_slot: 4'(slot_reg)};
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // capture the transaction on accept
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
            req_reg <= req;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accept did not raise busy");

    // one result per transaction, never two strobes in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("back to back result strobes");

    // a bucket never counts past its capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (cnt_wdata <= CNTW'(CAPACITY)))
        else $error("bucket count above capacity");

    // a removal that finishes has found something in a non-empty bucket
    a_fin_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (cnt_reg != '0))
        else $error("remove from empty bucket");

endmodule

FILE: design/ugbt_div.sv
// shared restoring divider that turns an axis offset into a grid coordinate
module ugbt_div #(
    parameter int MAX_DEPTH = ugbt_pkg::MAX_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic [31:0]                          num,
    input  logic [31:0]                          den,
    input  logic [$clog2(MAX_DEPTH + 1) - 1:0]   depth,
    output logic                                 done,
    output logic [MAX_DEPTH - 1:0]               coord
);

    localparam int AW = MAX_DEPTH;
    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic          run_reg;
    logic          first_reg;
    logic          sat_reg;
    logic          done_reg;
    logic [DW-1:0] cnt_reg;
    logic [DW-1:0] depth_reg;
    logic [AW-1:0] q_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   den_reg;

    logic          ge;
    logic [32:0]   rem_sub;
    logic [AW-1:0] last_cell;

    assign ge        = rem_reg >= {1'b0, den_reg};
    assign rem_sub   = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign last_cell = AW'((32'd1 << depth_reg) - 32'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (cnt_reg == '0))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg   <= {1'b0, num};
            den_reg   <= den;
            cnt_reg   <= depth;
            depth_reg <= depth;
            first_reg <= 1'b1;
            sat_reg   <= 1'b0;
            q_reg     <= '0;
        end
        else if (run_reg)
        begin
            // first step yields the weight 2^depth bit: only set on the upper bound
            if (first_reg)
            begin
                sat_reg <= ge;
            end
            else
            begin
                q_reg <= AW'({q_reg, ge});
            end
            first_reg <= 1'b0;
            rem_reg   <= {rem_sub[31:0], 1'b0};
            cnt_reg   <= cnt_reg - DW'(1);
        end
    end

    assign done  = done_reg;
    assign coord = sat_reg ? last_cell : q_reg;

endmodule
